FILE: hw/rtl/clt_pkg.sv
// Package for the config line tokenizer: character codes, default parameters
// and the result record passed from the parser to the output register.
// No dependencies.
package clt_pkg;

  localparam int DefMaxArgs   = 32;
  localparam int DefLineBytes = 256;

  localparam logic [5:0] ArgCapReset = 6'd32;

  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChVt    = 8'd11;
  localparam logic [7:0] ChFf    = 8'd12;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChHash  = 8'd35;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       token_end;
    logic [4:0] arg_index;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChTab) || (b == ChVt) || (b == ChFf) || (b == ChCr) || (b == ChSpace);
  endfunction

endpackage

FILE: hw/rtl/clt_parse.sv
// Tokenizer parse step: parser state registers and the next-state logic for one byte.
// Depends on clt_pkg.
module clt_parse import clt_pkg::*; #(
  parameter int MAX_ARGS   = DefMaxArgs,
  parameter int LINE_BYTES = DefLineBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_file_i,
  input  logic [5:0] arg_cap_i,
  output result_t    res_o
);

  typedef enum logic [1:0] {
    ModeSpace  = 2'd0,
    ModeBare   = 2'd1,
    ModeQuoted = 2'd2
  } mode_e;

  localparam logic [5:0] MaxArgsC  = 6'(MAX_ARGS);
  localparam logic [8:0] LineLastC = 9'(LINE_BYTES - 1);

  mode_e      mode_q, mode_d;
  logic       open_q, open_d;
  logic [7:0] lc_q, lc_d;
  logic       skip_q, skip_d;
  logic [5:0] args_q, args_d;
  logic       fin_q, fin_d;

  logic [5:0] limit;
  logic [5:0] args_inc;
  logic       do_close, do_emit, new_line;

  assign limit    = (arg_cap_i < MaxArgsC) ? arg_cap_i : MaxArgsC;
  assign args_inc = args_q + 6'd1;

  always_comb begin
    mode_d   = mode_q;
    open_d   = open_q;
    lc_d     = lc_q;
    skip_d   = skip_q;
    args_d   = args_q;
    fin_d    = fin_q;
    do_close = 1'b0;
    do_emit  = 1'b0;
    new_line = 1'b0;

    if (fin_q || (args_q >= limit)) begin
      fin_d = 1'b1;
    end else if (skip_q && open_q) begin
      do_close = 1'b1;
      if (end_of_file_i) begin
        fin_d = 1'b1;
      end else if (in_byte_i == ChNl) begin
        new_line = 1'b1;
      end
    end else if (end_of_file_i) begin
      do_close = open_q;
      fin_d    = 1'b1;
    end else if (in_byte_i == ChNl) begin
      do_close = open_q;
      new_line = 1'b1;
    end else if (!skip_q) begin
      lc_d = lc_q + 8'd1;
      if (in_byte_i == ChNul) begin
        do_close = open_q;
        skip_d   = 1'b1;
      end else begin
        case (mode_q)
          ModeBare: begin
            if ((in_byte_i == ChHash) || is_blank(in_byte_i)) begin
              do_close = 1'b1;
              if (in_byte_i == ChHash) skip_d = 1'b1;
            end else begin
              do_emit = 1'b1;
            end
          end
          ModeQuoted: begin
            if (in_byte_i == ChQuote) do_close = 1'b1;
            else                      do_emit  = 1'b1;
          end
          default: begin
            if (in_byte_i == ChHash) begin
              skip_d = 1'b1;
            end else if (is_blank(in_byte_i)) begin
              skip_d = skip_q;
            end else if (in_byte_i == ChQuote) begin
              mode_d = ModeQuoted;
              open_d = 1'b1;
            end else begin
              mode_d  = ModeBare;
              open_d  = 1'b1;
              do_emit = 1'b1;
            end
          end
        endcase
      end
      if ({1'b0, lc_d} >= LineLastC) skip_d = 1'b1;
    end

    if (do_close) begin
      open_d = 1'b0;
      mode_d = ModeSpace;
      args_d = args_inc;
      if (args_inc >= limit) fin_d = 1'b1;
    end
    if (new_line) begin
      lc_d   = 8'd0;
      skip_d = 1'b0;
      mode_d = ModeSpace;
    end
  end

  always_comb begin
    res_o.valid     = do_close || do_emit;
    res_o.out_byte  = do_emit ? in_byte_i : 8'd0;
    res_o.token_end = do_close;
    res_o.arg_index = args_q[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSpace;
      open_q <= 1'b0;
      lc_q   <= 8'd0;
      skip_q <= 1'b0;
      args_q <= 6'd0;
      fin_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      open_q <= open_d;
      lc_q   <= lc_d;
      skip_q <= skip_d;
      args_q <= args_d;
      fin_q  <= fin_d;
    end
  end

  a_end_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.token_end) |-> (res_o.out_byte == 8'd0))
    else $error("token end carries a byte");

  a_finished_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !res_o.valid)
    else $error("result after finish");

  a_mode_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeSpace) |-> open_q)
    else $error("token mode without open token");

  a_close_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && res_o.token_end) |=> (args_q == 6'($past(args_q) + 6'd1)))
    else $error("argument count did not advance on token end");

endmodule

FILE: hw/rtl/clt_out_reg.sv
// Result register for the tokenizer: holds one result until the sink takes it.
// Depends on clt_pkg.
module clt_out_reg import clt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     res_i,
  output logic        ready_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic [4:0] idx_q;

  assign ready_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      byte_q <= res_i.out_byte;
      end_q  <= res_i.token_end;
      idx_q  <= res_i.arg_index;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {3'd0, idx_q, byte_q};
  assign m_axis_tuser_o  = end_q;

endmodule

FILE: hw/rtl/config_line_tokenizer.sv
// Top level of the config line tokenizer: input register, parse step, result register.
// Depends on clt_pkg, clt_parse and clt_out_reg.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata[7:0] in_byte, tuser end_of_file
//  m_axis   | out | tdata[7:0] out_byte, tdata[12:8] arg_index; tuser token_end
//  cfg      | in  | cfg_wdata_i[5:0] argument cap, written when cfg_we_i is high
//
// One byte per clock while the sink keeps up: each transaction waits in the input
// register for the parse step, and its result (if any) is then loaded into the result
// register, from which the sink can take it.
// Reset clears parser state and sets the argument cap to 32.
// A stalled sink holds the result register; the input register then holds too.
module config_line_tokenizer import clt_pkg::*; #(
  parameter int MAX_ARGS   = DefMaxArgs,
  parameter int LINE_BYTES = DefLineBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [12:8] arg_index
  output logic        m_axis_tuser,   // [0] token_end
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eof_q;
  logic [5:0] arg_cap_q;
  logic       out_ready;
  logic       step;
  result_t    res;

  assign step          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      arg_cap_q  <= ArgCapReset;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (cfg_we_i) arg_cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tuser;
    end
  end

  clt_parse #(
    .MAX_ARGS   (MAX_ARGS),
    .LINE_BYTES (LINE_BYTES)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .in_byte_i     (in_byte_q),
    .end_of_file_i (in_eof_q),
    .arg_cap_i     (arg_cap_q),
    .res_o         (res)
  );

  clt_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && res.valid),
    .res_i           (res),
    .ready_o         (out_ready),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for config_line_tokenizer: directed and random byte streams
// on the stream ports, checked against an in-bench argument tokenizer model.
// Depends on clt_pkg and config_line_tokenizer.
`timescale 1ns / 1ps

module testbench;
  import clt_pkg::*;

  localparam int ClkHalf     = 4;
  localparam int ResetCycles = 5;
  localparam int DrainCycles = 6;
  localparam int CycleLimit  = 400000;
  localparam int ArgBudget   = 29;
  localparam int PrintCap    = 40;

  typedef enum logic [1:0] {
    SCAN_GAP    = 2'd0,
    SCAN_BARE   = 2'd1,
    SCAN_QUOTED = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       token_end;
    logic [4:0] arg;
  } token_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tuser;   // [0] end_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] out_byte, [12:8] arg_index
  logic        m_axis_tuser;   // [0] token_end
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;

  config_line_tokenizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  token_result_t expected_tokens[$];
  token_result_t want_q;

  scan_mode_e  scan_mode;
  logic        in_token;
  int          line_len;
  logic        drop_line;
  int          args_seen;
  logic        stream_done;
  logic [5:0]  cap_reg;

  int send_idle_pct;
  int stall_pct;
  int hold_off_left;
  int items_in;
  int results_checked;
  int mismatches;
  int cycles;

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PrintCap) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    end
    mismatches++;
  endtask

  // Sink side: long hold-off when requested, random stalls otherwise.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected result", int'({m_axis_tuser, m_axis_tdata[12:0]}), 0);
      end else begin
        want_q = expected_tokens.pop_front();
        if (m_axis_tdata[7:0] !== want_q.ch)
          report_mismatch("out_byte", int'(m_axis_tdata[7:0]), int'(want_q.ch));
        if (m_axis_tuser !== want_q.token_end)
          report_mismatch("token_end", int'(m_axis_tuser), int'(want_q.token_end));
        if (m_axis_tdata[12:8] !== want_q.arg)
          report_mismatch("arg_index", int'(m_axis_tdata[12:8]), int'(want_q.arg));
      end
    end
  end

  function automatic logic is_space_char(input logic [7:0] c);
    return c == ChTab || c == ChVt || c == ChFf || c == ChCr || c == ChSpace;
  endfunction

  function automatic int arg_cap();
    return (cap_reg < 6'(DefMaxArgs)) ? int'(cap_reg) : DefMaxArgs;
  endfunction

  task automatic close_arg();
    expected_tokens.push_back('{ch: 8'h00, token_end: 1'b1, arg: args_seen[4:0]});
    in_token  = 1'b0;
    scan_mode = SCAN_GAP;
    args_seen = (args_seen + 1) & 63;
    if (args_seen >= arg_cap()) stream_done = 1'b1;
  endtask

  task automatic start_line();
    line_len  = 0;
    drop_line = 1'b0;
    scan_mode = SCAN_GAP;
  endtask

  task automatic emit_char(input logic [7:0] c);
    expected_tokens.push_back('{ch: c, token_end: 1'b0, arg: args_seen[4:0]});
  endtask

  task automatic tokenize_step(input logic [7:0] c, input logic eof);
    if (stream_done || args_seen >= arg_cap()) begin
      stream_done = 1'b1;
      return;
    end
    if (drop_line && in_token) begin
      close_arg();
      if (eof) stream_done = 1'b1;
      else if (c == ChNl) start_line();
      return;
    end
    if (eof) begin
      if (in_token) close_arg();
      stream_done = 1'b1;
      return;
    end
    if (c == ChNl) begin
      if (in_token) close_arg();
      start_line();
      return;
    end
    if (drop_line) return;
    line_len++;
    if (c == ChNul) begin
      if (in_token) close_arg();
      drop_line = 1'b1;
      return;
    end
    case (scan_mode)
      SCAN_BARE: begin
        if (c == ChHash || is_space_char(c)) begin
          close_arg();
          if (c == ChHash) drop_line = 1'b1;
        end else begin
          emit_char(c);
        end
      end
      SCAN_QUOTED: begin
        if (c == ChQuote) close_arg();
        else emit_char(c);
      end
      default: begin
        if (c == ChHash) begin
          drop_line = 1'b1;
        end else if (c == ChQuote) begin
          scan_mode = SCAN_QUOTED;
          in_token  = 1'b1;
        end else if (!is_space_char(c)) begin
          scan_mode = SCAN_BARE;
          in_token  = 1'b1;
          emit_char(c);
        end
      end
    endcase
    if (line_len >= DefLineBytes - 1) drop_line = 1'b1;
  endtask

  // Call at a falling edge; returns at a falling edge.
  task automatic send_item(input logic [7:0] c, input logic eof);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    items_in++;
    tokenize_step(c, eof);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_arg_cap(input logic [5:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg     = v;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(4))
      0:       return ChTab;
      1:       return ChVt;
      2:       return ChFf;
      3:       return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  task automatic send_blanks(input int n);
    int i;
    for (i = 0; i < n; i++) send_item(pick_blank(), 1'b0);
  endtask

  task automatic send_bare(input int n);
    int i;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      do c = 8'($urandom_range(1, 255)); while (c == ChNl || c == ChHash || is_space_char(c));
      send_item(c, 1'b0);
    end
  endtask

  task automatic send_quoted(input int n, input logic closed);
    int i;
    logic [7:0] c;
    send_item(ChQuote, 1'b0);
    for (i = 0; i < n; i++) begin
      do c = 8'($urandom_range(1, 255)); while (c == ChNl || c == ChQuote);
      send_item(c, 1'b0);
    end
    if (closed) send_item(ChQuote, 1'b0);
  endtask

  task automatic send_junk(input int n);
    int i;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChNl);
      send_item(c, 1'b0);
    end
  endtask

  task automatic send_random_line();
    int shape;
    int k;
    int i;
    shape = $urandom_range(99);
    k = (shape < 55) ? $urandom_range(1, 3) : (shape >= 93) ? $urandom_range(1, 8) :
        (shape >= 72) ? 1 : 0;
    if (args_seen + k > ArgBudget) shape = 60;
    if (shape < 55) begin
      send_blanks($urandom_range(0, 2));
      for (i = 0; i < k; i++) begin
        if ($urandom_range(9) < 6) send_bare($urandom_range(1, 60));
        else send_quoted($urandom_range(0, 50), 1'b1);
        if (i == k - 1) begin
          if ($urandom_range(4) == 0) begin
            if ($urandom_range(1)) send_blanks($urandom_range(0, 2));
            send_item(ChHash, 1'b0);
            send_junk($urandom_range(0, 15));
          end
        end else begin
          send_blanks($urandom_range(1, 3));
        end
      end
    end else if (shape < 65) begin
      send_blanks($urandom_range(0, 2));
      send_item(ChHash, 1'b0);
      send_junk($urandom_range(0, 20));
    end else if (shape < 72) begin
      send_blanks($urandom_range(0, 4));
    end else if (shape < 80) begin
      send_quoted($urandom_range(0, 30), 1'b0);
    end else if (shape < 88) begin
      send_bare($urandom_range(1, 20));
      send_item(ChNul, 1'b0);
      send_junk($urandom_range(0, 10));
    end else if (shape < 93) begin
      send_blanks($urandom_range(0, 3));
      send_bare($urandom_range(250, 280));
      send_junk($urandom_range(0, 5));
    end else begin
      for (i = 0; i < k; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
    end
    send_item(ChNl, 1'b0);
  endtask

  task automatic test_token_rules();
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(ChVt, 1'b0);
    send_text("\"\" \"a #\"");
    send_item(ChFf, 1'b0);
    send_item(ChTab, 1'b0);
    send_text("b#c");
    send_item(ChNl, 1'b0);
    send_item(ChCr, 1'b0);
    send_text("\"q");
    send_item(ChNl, 1'b0);
    send_text("d");
    send_item(ChNul, 1'b0);
    send_text("e");
    send_item(ChNl, 1'b0);
    settle();
  endtask

  task automatic test_long_line();
    send_item(ChSpace, 1'b0);
    send_bare(DefLineBytes + 10);
    send_item(ChNl, 1'b0);
    send_quoted(DefLineBytes, 1'b1);
    send_item(ChNl, 1'b0);
    settle();
  endtask

  // Hold the sink off while the source streams at full rate.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_left = 80;
    send_quoted(60, 1'b1);
    send_item(ChNl, 1'b0);
    settle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall, input int n_items,
                                   input logic [5:0] cap);
    int stop_at;
    write_arg_cap(cap);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    stop_at       = items_in + n_items;
    while (items_in < stop_at) send_random_line();
    settle();
  endtask

  task automatic test_eof_and_limit();
    send_idle_pct = 20;
    stall_pct     = 20;
    write_arg_cap(6'(args_seen + 1));
    send_text("\"z");
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_text("late x");
    send_item(ChNl, 1'b0);
    write_arg_cap(6'd63);
    send_text("y ");
    write_arg_cap(6'd0);
    send_text("w ");
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    s_axis_tuser    = 1'b0;
    m_axis_tready   = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 6'd0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_left   = 0;
    items_in        = 0;
    results_checked = 0;
    mismatches      = 0;
    cycles          = 0;
    cap_reg         = ArgCapReset;
    args_seen       = 0;
    in_token        = 1'b0;
    stream_done     = 1'b0;
    start_line();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_token_rules();
    write_arg_cap(6'd63);
    test_long_line();
    test_backpressure();
    test_random_phase(0, 0, 150, 6'd63);
    test_random_phase(45, 0, 150, 6'd33);
    test_random_phase(0, 45, 150, 6'd32);
    test_random_phase(20, 20, 150, 6'd48);
    test_eof_and_limit();

    $display("summary: %0d input transactions, %0d results checked, %0d arguments closed",
             items_in, results_checked, args_seen);
    $display("summary: quotes, comments, NUL and long lines, stalls, limit and end of file");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
